>>> hdl/crsi_pkg.sv
// Shared types and constants of the custom-radix string to integer unit.
package crsi_pkg;

    // Item kinds.
    localparam logic OP_ALPHABET = 1'b0;
    localparam logic OP_STRING   = 1'b1;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // One input item.
    typedef struct packed {
        logic       operation;
        logic [7:0] symbol;
        logic       last;
    } item_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] value;
        logic               base_valid;
    } result_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        item_t item;
        logic  bad_char;
        logic  space;
        logic  plus;
        logic  minus;
    } cmd_t;

    // Parser phase of the current string.
    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } phase_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_DELIVER
    } back_state_t;

endpackage

>>> hdl/crsi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module crsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/crsi_front.sv
// Front end: accepts items, classifies each byte and queues it for the back end.
module crsi_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  crsi_pkg::item_t item,
    output logic          cmd_valid,
    output crsi_pkg::cmd_t  cmd,
    input  logic          cmd_take
);
    import crsi_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       do_push;
    logic       do_pop;

    // Classify the incoming byte.
    always_comb
    begin
        cls.item     = item;
        cls.plus     = (item.symbol == CH_PLUS);
        cls.minus    = (item.symbol == CH_MINUS);
        cls.space    = (item.symbol == CH_SPACE) ||
                       ((item.symbol >= CH_TAB) && (item.symbol <= CH_CR));
        cls.bad_char = (item.symbol <= CH_SPACE) || (item.symbol >= CH_DEL) ||
                       cls.plus || cls.minus;
    end

    // Two-entry queue control.
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> hdl/crsi_back.sv
// Back end: alphabet search sequencer, accumulator and result register.
module crsi_back #(
    parameter int MAX_ALPHABET = 128,
    parameter int VALUE_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  crsi_pkg::cmd_t    cmd,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output crsi_pkg::result_t result
);
    import crsi_pkg::*;

    localparam int AW = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
    localparam int LW = $clog2(MAX_ALPHABET + 1);

    back_state_t     state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            bad_reg, bad_next;
    logic            complete_reg, complete_next;
    phase_t          phase_reg, phase_next;
    logic            neg_reg, neg_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   digit_reg, digit_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            go_search;
    logic [VALUE_BITS-1:0] mac;
    logic [VALUE_BITS-1:0] signed_acc;

    // Alphabet storage.
    crsi_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ALPHABET)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.item.symbol),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Digit accumulate and sign application.
    assign mac        = acc_reg * VALUE_BITS'(len_reg) + VALUE_BITS'(digit_reg);
    assign signed_acc = neg_reg ? (VALUE_BITS'(0) - acc_reg) : acc_reg;
    assign ram_waddr  = len_reg[AW-1:0];
    assign ram_raddr  = idx_reg[AW-1:0];
    assign empty      = !out_valid_reg;
    assign result     = out_reg;

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        bad_next       = bad_reg;
        complete_next  = complete_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        ram_we         = 1'b0;
        go_search      = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    if (cmd.item.operation == OP_ALPHABET)
                    begin
                        // A byte after a completed alphabet starts a new one.
                        if (complete_reg)
                        begin
                            len_next      = '0;
                            bad_next      = 1'b0;
                            complete_next = 1'b0;
                            phase_next    = PH_SPACE;
                            neg_next      = 1'b0;
                            acc_next      = '0;
                        end
                        if (cmd.bad_char)
                        begin
                            bad_next = 1'b1;
                        end
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        unique case (phase_reg) inside
                            PH_SPACE, PH_SIGN:
                            begin
                                if (phase_reg == PH_SPACE && cmd.space)
                                begin
                                    phase_next = PH_SPACE;
                                end
                                else if (cmd.plus)
                                begin
                                    phase_next = PH_SIGN;
                                end
                                else if (cmd.minus)
                                begin
                                    phase_next = PH_SIGN;
                                    neg_next   = !neg_reg;
                                end
                                else
                                begin
                                    phase_next = PH_DIGIT;
                                    go_search  = 1'b1;
                                end
                            end
                            PH_DIGIT:
                            begin
                                go_search = 1'b1;
                            end
                            default:
                            begin
                                go_search = 1'b0;
                            end
                        endcase
                        if (go_search)
                        begin
                            state_next = ST_SEARCH;
                        end
                        else if (cmd.item.last)
                        begin
                            state_next = ST_DELIVER;
                        end
                        else
                        begin
                            cmd_take = 1'b1;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // One table read issued and one compare done per cycle.
                if (cmp_valid_reg && ram_rdata == cmd.item.symbol)
                begin
                    found_next     = 1'b1;
                    digit_next     = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_APPLY;
                end
                else if (idx_reg < len_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[AW-1:0];
                    idx_next       = idx_reg + LW'(1);
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end

            ST_APPLY:
            begin
                if (cmd.item.operation == OP_ALPHABET)
                begin
                    if (found_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    if (len_reg >= LW'(MAX_ALPHABET))
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        len_next = len_reg + LW'(1);
                    end
                    if (cmd.item.last)
                    begin
                        complete_next = 1'b1;
                    end
                    cmd_take   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (found_reg)
                    begin
                        acc_next = mac;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                    if (cmd.item.last)
                    begin
                        state_next = ST_DELIVER;
                    end
                    else
                    begin
                        cmd_take   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_DELIVER:
            begin
                // Load the result register once it is free, then reset the parser.
                if (!out_valid_reg || pop)
                begin
                    out_valid_next      = 1'b1;
                    out_next.base_valid = complete_reg && !bad_reg && (len_reg >= LW'(2));
                    out_next.value      = out_next.base_valid ? 32'(signed_acc) : 32'sd0;
                    phase_next          = PH_SPACE;
                    neg_next            = 1'b0;
                    acc_next            = '0;
                    cmd_take            = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            complete_reg  <= 1'b0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            bad_reg       <= bad_next;
            complete_reg  <= complete_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        digit_reg   <= digit_next;
        out_reg     <= out_next;
    end

    // The stored alphabet never exceeds the table.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_ALPHABET))
        else $error("alphabet length exceeds table depth");

    // The search pointer never runs past the stored alphabet.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> idx_reg <= len_reg)
        else $error("search index past alphabet length");

    // The table is written only when an alphabet byte is applied.
    a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_APPLY && cmd.item.operation == OP_ALPHABET))
        else $error("table written outside alphabet update");

    // Leaving the delivery state always leaves a result waiting.
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("delivered item missing from result register");

    // An item is released only while the queue holds one.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("item released from an empty queue");

endmodule

>>> hdl/custom_radix_string_to_integer_unit.sv
// Top level of the custom-radix string to integer unit.
// The unit is fed the digit alphabet one byte per item (operation 0, last on the
// final byte), then string bytes (operation 1); the last string byte yields one
// result holding the signed value, wrapped to VALUE_BITS and shown in 32 bits,
// and base_valid. Items enter a two-entry queue at one per cycle while it is
// not full; the back end then works each item in turn. Leading whitespace and
// sign bytes skip the search; alphabet bytes and digit bytes search the stored
// alphabet through the table's single read port, one entry per cycle.
// The result register lets the next item proceed while a result waits to be popped.
module custom_radix_string_to_integer_unit #(
    parameter int MAX_ALPHABET = 128,
    parameter int VALUE_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  crsi_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output crsi_pkg::result_t result
);
    import crsi_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    // Accept and classify.
    crsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Search, accumulate and deliver.
    crsi_back #(
        .MAX_ALPHABET (MAX_ALPHABET),
        .VALUE_BITS   (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
